### design/lph_pkg.sv
// Shared types, constants and codes for the linear probing hash table.
`default_nettype none
package lph_pkg;

  localparam int MAX_SLOTS   = 1024;
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int KEY_W       = 32;
  localparam int SCR_DEPTH   = MAX_SLOTS / 2;
  localparam int SCR_W       = $clog2(SCR_DEPTH);
  localparam int DIV_STEPS   = KEY_W;
  localparam int DIVC_W      = $clog2(DIV_STEPS);
  localparam int D_W         = (CNT_W + 1) / 2 + 1;
  localparam int RESET_SLOTS = 11;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_SEARCH = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_STATUS = 3'd3;
  localparam logic [2:0] OP_SIZE   = 3'd4;

  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_ACTIVE  = 2'd1;
  localparam logic [1:0] ST_DELETED = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_GROW  = 2'd2;

  typedef struct packed {
    logic [2:0]        op;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot_index;
  } in_pkt_t;

  typedef struct packed {
    logic              found;
    logic [KEY_W-1:0]  slot_key;
    logic [1:0]        slot_state;
    logic [CNT_W-1:0]  current_slots;
    logic [1:0]        error;
  } out_pkt_t;

  typedef struct packed {
    logic [1:0]       st;
    logic [KEY_W-1:0] key;
  } slot_ent_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH,
    S_PR_START, S_PR_TEST, S_PR_DIV, S_PR_CHK,
    S_GS_RD, S_GS_CHK,
    S_REH_NEXT, S_REH_WAIT, S_PLACE_NEW, S_DIV_KEY, S_PDIV, S_P_SET, S_P_RD, S_P_CHK,
    S_SC_RD, S_SC_CHK, S_STAT, S_RESP
  } ctrl_state_t;

  typedef enum logic [1:0] {RD_SCAN, RD_POS, RD_IDX} rd_src_t;
  typedef enum logic [1:0] {WR_NONE, WR_CLEAR, WR_PLACE, WR_DEL} wr_t;

  typedef struct packed {
    logic    load_item;
    logic    scan_clr;
    logic    scan_inc;
    logic    set_err1;
    logic    set_err2;
    logic    cand_init;
    logic    cand_inc;
    logic    d_init;
    logic    d_inc;
    logic    set_new_slots;
    logic    scr_push;
    logic    apply_new_slots;
    logic    reh_load;
    logic    new_load;
    logic    div_start_prime;
    logic    div_start_key;
    logic    div_step;
    logic    pos_load;
    logic    pos_inc;
    logic    set_found;
    logic    del_hit;
    logic    stat_capture;
    logic    resp_load;
    rd_src_t rd_src;
    wr_t     wr;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       need_grow;
    logic       dbl_over;
    logic       idx_bad;
    logic       cand_over;
    logic       sq_gt;
    logic       div_last;
    logic       rem_zero;
    logic       mem_active;
    logic       key_match;
    logic       scan_last;
    logic       scan_last_full;
    logic       probe_last;
    logic       scr_done;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

### design/linear_probing_hash_table.sv
// Top level of the open-addressing hash table with linear probing.
//
//   Channel  Signals                     Direction  Contents
//   in       in_valid, in_stall, in_data  into      op, key, slot_index
//   out      out_valid, out_stall, out_data out of  found, slot_key, slot_state,
//                                                   current_slots, error
//   cfg      cfg_we, cfg_data             into      initial_slots
//
// One transaction is worked at a time. A status query reads the indexed slot; a size
// query goes straight from dispatch to the response. An insert without growth runs the
// 32-step remainder unit and then probes slot by slot. Search and delete walk the slot
// memory slot by slot, up to the table size. Growth runs a prime search by trial division
// over candidates, scans the old slots into scratch memory and clears them, and makes
// one placement per surviving key.
// After reset and after every configuration write all 1024 slots of the slot memory are
// cleared, during which in_stall is high. A finished result waits in the output
// register while out_stall is high; the next transaction is taken in meanwhile and
// holds in its last step until the output register is free.
`default_nettype none
module linear_probing_hash_table (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  lph_pkg::in_pkt_t         in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output lph_pkg::out_pkt_t        out_data,
  input  wire                      cfg_we,
  input  wire [lph_pkg::CNT_W-1:0] cfg_data
);
  import lph_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences every operation; the datapath holds all storage.
  lph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cfg_we   (cfg_we),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  lph_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### design/lph_ctrl.sv
// Controller state machine of the hash table: sequences probing, scans and growth.
`default_nettype none
module lph_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  input  wire              cfg_we,
  input  lph_pkg::dp_stat_t stat,
  output lph_pkg::dp_cmd_t  cmd,
  output logic             in_stall
);
  import lph_pkg::*;

  ctrl_state_t state, state_next;
  logic ctx_grow, ctx_grow_next;
  logic ctx_new, ctx_new_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      ctx_grow <= 1'b0;
      ctx_new  <= 1'b0;
    end else begin
      state    <= state_next;
      ctx_grow <= ctx_grow_next;
      ctx_new  <= ctx_new_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctx_grow_next = ctx_grow;
    ctx_new_next  = ctx_new;
    unique case (state)
      S_CLEAR: begin
        if (ctx_grow ? stat.scan_last : stat.scan_last_full) begin
          state_next = ctx_grow ? S_REH_NEXT : S_IDLE;
        end
      end
      S_IDLE: if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (stat.op) inside
          OP_INSERT: begin
            if (!stat.need_grow) state_next = S_PLACE_NEW;
            else if (stat.dbl_over) state_next = S_RESP;
            else state_next = S_PR_START;
          end
          OP_SEARCH, OP_DELETE: state_next = S_SC_RD;
          OP_STATUS: state_next = stat.idx_bad ? S_RESP : S_STAT;
          default: state_next = S_RESP;
        endcase
      end
      S_PR_START: state_next = stat.cand_over ? S_RESP : S_PR_TEST;
      S_PR_TEST:  state_next = stat.sq_gt ? S_GS_RD : S_PR_DIV;
      S_PR_DIV:   if (stat.div_last) state_next = S_PR_CHK;
      S_PR_CHK:   state_next = stat.rem_zero ? S_PR_START : S_PR_TEST;
      S_GS_RD:    state_next = S_GS_CHK;
      S_GS_CHK: begin
        if (stat.scan_last) begin
          state_next    = S_CLEAR;
          ctx_grow_next = 1'b1;
        end else begin
          state_next = S_GS_RD;
        end
      end
      S_REH_NEXT: state_next = stat.scr_done ? S_PLACE_NEW : S_REH_WAIT;
      S_REH_WAIT: begin
        state_next   = S_DIV_KEY;
        ctx_new_next = 1'b0;
      end
      S_PLACE_NEW: begin
        state_next   = S_DIV_KEY;
        ctx_new_next = 1'b1;
      end
      S_DIV_KEY: state_next = S_PDIV;
      S_PDIV:    if (stat.div_last) state_next = S_P_SET;
      S_P_SET:   state_next = S_P_RD;
      S_P_RD:    state_next = S_P_CHK;
      S_P_CHK: begin
        if (!stat.mem_active || stat.probe_last) begin
          state_next = ctx_new ? S_RESP : S_REH_NEXT;
        end else begin
          state_next = S_P_RD;
        end
      end
      S_SC_RD: state_next = S_SC_CHK;
      S_SC_CHK: begin
        if ((stat.op == OP_SEARCH) && stat.mem_active && stat.key_match) state_next = S_RESP;
        else if (stat.scan_last) state_next = S_RESP;
        else state_next = S_SC_RD;
      end
      S_STAT: state_next = S_RESP;
      S_RESP: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
    if (cfg_we) begin
      state_next    = S_CLEAR;
      ctx_grow_next = 1'b0;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_src = RD_SCAN;
    cmd.wr     = WR_NONE;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.wr = WR_CLEAR;
        if (ctx_grow ? stat.scan_last : stat.scan_last_full) begin
          cmd.scan_clr        = 1'b1;
          cmd.apply_new_slots = ctx_grow;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_IDLE: cmd.load_item = in_valid;
      S_DISPATCH: begin
        cmd.rd_src = RD_IDX;
        if (stat.op == OP_INSERT && stat.need_grow) begin
          cmd.set_err2  = stat.dbl_over;
          cmd.cand_init = !stat.dbl_over;
        end
        if (stat.op == OP_STATUS) cmd.set_err1 = stat.idx_bad;
      end
      S_PR_START: begin
        cmd.set_err2 = stat.cand_over;
        cmd.d_init   = !stat.cand_over;
      end
      S_PR_TEST: begin
        cmd.set_new_slots   = stat.sq_gt;
        cmd.div_start_prime = !stat.sq_gt;
      end
      S_PR_DIV: cmd.div_step = 1'b1;
      S_PR_CHK: begin
        cmd.cand_inc = stat.rem_zero;
        cmd.d_inc    = !stat.rem_zero;
      end
      S_GS_RD: cmd.rd_src = RD_SCAN;
      S_GS_CHK: begin
        cmd.scr_push = stat.mem_active;
        cmd.scan_clr = stat.scan_last;
        cmd.scan_inc = !stat.scan_last;
      end
      S_REH_NEXT:  cmd.rd_src = RD_SCAN;
      S_REH_WAIT:  cmd.reh_load = 1'b1;
      S_PLACE_NEW: cmd.new_load = 1'b1;
      S_DIV_KEY:   cmd.div_start_key = 1'b1;
      S_PDIV:      cmd.div_step = 1'b1;
      S_P_SET:     cmd.pos_load = 1'b1;
      S_P_RD:      cmd.rd_src = RD_POS;
      S_P_CHK: begin
        if (!stat.mem_active) cmd.wr = WR_PLACE;
        else if (!stat.probe_last) cmd.pos_inc = 1'b1;
      end
      S_SC_RD: cmd.rd_src = RD_SCAN;
      S_SC_CHK: begin
        if (stat.mem_active && stat.key_match) begin
          if (stat.op == OP_SEARCH) begin
            cmd.set_found = 1'b1;
          end else begin
            cmd.wr      = WR_DEL;
            cmd.del_hit = 1'b1;
          end
        end
        cmd.scan_inc = !stat.scan_last;
      end
      S_STAT: cmd.stat_capture = 1'b1;
      S_RESP: cmd.resp_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/lph_dp.sv
// Datapath of the hash table: slot memory, scratch memory, divider and counters.
`default_nettype none
module lph_dp (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire [lph_pkg::CNT_W-1:0] cfg_data,
  input  lph_pkg::in_pkt_t       in_data,
  input  wire                    out_stall,
  input  lph_pkg::dp_cmd_t       cmd,
  output lph_pkg::dp_stat_t      stat,
  output logic                   out_valid,
  output lph_pkg::out_pkt_t      out_data
);
  import lph_pkg::*;

  slot_ent_t mem [MAX_SLOTS];
  logic [KEY_W-1:0] scr [SCR_DEPTH];

  in_pkt_t           item;
  logic [CNT_W-1:0]  table_slots;
  logic [CNT_W-1:0]  live_count;
  logic [CNT_W-1:0]  new_slots;
  logic [CNT_W-1:0]  scan;
  logic [SLOT_W-1:0] pos;
  logic [CNT_W-1:0]  probe_cnt;
  logic [SCR_W:0]    scr_cnt;
  logic [SCR_W:0]    scr_rd;
  logic [KEY_W-1:0]  scr_q;
  logic [CNT_W-1:0]  cand;
  logic [D_W-1:0]    dcnt;
  logic [KEY_W-1:0]  place_key;
  logic [KEY_W-1:0]  div_a;
  logic [CNT_W-1:0]  div_d;
  logic [CNT_W-1:0]  div_r;
  logic [DIVC_W-1:0] div_cnt;
  slot_ent_t         rd_ent;
  logic              found_r;
  logic [1:0]        err_r;
  logic [KEY_W-1:0]  skey_r;
  logic [1:0]        sst_r;

  logic [CNT_W-1:0]  cfg_slots;
  logic [CNT_W:0]    rs;
  logic [CNT_W+1:0]  cnt2;
  logic [2*D_W-1:0]  dsq;
  logic              mem_we;
  logic [SLOT_W-1:0] wr_addr;
  logic [SLOT_W-1:0] rd_addr;
  slot_ent_t         wr_ent;

  always_comb begin
    if (cfg_data == '0) cfg_slots = CNT_W'(1);
    else if (cfg_data > CNT_W'(MAX_SLOTS)) cfg_slots = CNT_W'(MAX_SLOTS);
    else cfg_slots = cfg_data;
  end

  assign rs   = {div_r, div_a[KEY_W-1]};
  assign cnt2 = {(CNT_W+1)'(live_count) + (CNT_W+1)'(1), 1'b0};
  assign dsq  = (2*D_W)'(dcnt) * (2*D_W)'(dcnt);

  always_comb begin
    stat.op             = item.op;
    stat.need_grow      = cnt2 >= (CNT_W+2)'(table_slots);
    stat.dbl_over       = {table_slots, 1'b0} > (CNT_W+1)'(MAX_SLOTS);
    stat.idx_bad        = {1'b0, item.slot_index} >= table_slots;
    stat.cand_over      = cand > CNT_W'(MAX_SLOTS);
    stat.sq_gt          = dsq > (2*D_W)'(cand);
    stat.div_last       = div_cnt == DIVC_W'(DIV_STEPS - 1);
    stat.rem_zero       = div_r == '0;
    stat.mem_active     = rd_ent.st == ST_ACTIVE;
    stat.key_match      = rd_ent.key == item.key;
    stat.scan_last      = scan == table_slots - CNT_W'(1);
    stat.scan_last_full = scan == CNT_W'(MAX_SLOTS - 1);
    stat.probe_last     = probe_cnt == table_slots - CNT_W'(1);
    stat.scr_done       = scr_rd == scr_cnt;
    stat.out_free       = !out_valid || !out_stall;
  end

  always_comb begin
    mem_we  = 1'b1;
    wr_addr = scan[SLOT_W-1:0];
    wr_ent  = '{st: ST_EMPTY, key: '0};
    unique case (cmd.wr)
      WR_NONE:  mem_we = 1'b0;
      WR_CLEAR: wr_ent = '{st: ST_EMPTY, key: '0};
      WR_PLACE: begin
        wr_addr = pos;
        wr_ent  = '{st: ST_ACTIVE, key: place_key};
      end
      WR_DEL:   wr_ent = '{st: ST_DELETED, key: rd_ent.key};
      default:  mem_we = 1'b0;
    endcase
    unique case (cmd.rd_src)
      RD_SCAN: rd_addr = scan[SLOT_W-1:0];
      RD_POS:  rd_addr = pos;
      RD_IDX:  rd_addr = item.slot_index;
      default: rd_addr = scan[SLOT_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_ent;
    rd_ent <= mem[rd_addr];
    if (cmd.scr_push) scr[scr_cnt[SCR_W-1:0]] <= rd_ent.key;
    scr_q <= scr[scr_rd[SCR_W-1:0]];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_slots <= CNT_W'(RESET_SLOTS);
      live_count  <= '0;
      scan        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.resp_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        table_slots <= cfg_slots;
        live_count  <= '0;
        scan        <= '0;
      end else begin
        if (cmd.apply_new_slots) table_slots <= new_slots;
        if (cmd.new_load) live_count <= live_count + CNT_W'(1);
        else if (cmd.del_hit && live_count != '0) live_count <= live_count - CNT_W'(1);
        if (cmd.scan_clr || cmd.load_item || cmd.set_new_slots) scan <= '0;
        else if (cmd.scan_inc) scan <= scan + CNT_W'(1);
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item    <= in_data;
      found_r <= 1'b0;
      err_r   <= ERR_OK;
      skey_r  <= '0;
      sst_r   <= ST_EMPTY;
    end
    if (cmd.set_err1) err_r <= ERR_RANGE;
    if (cmd.set_err2) err_r <= ERR_GROW;
    if (cmd.set_found) found_r <= 1'b1;
    if (cmd.stat_capture) begin
      skey_r <= rd_ent.key;
      sst_r  <= rd_ent.st;
    end
    if (cmd.cand_init) cand <= CNT_W'({table_slots, 1'b0});
    else if (cmd.cand_inc) cand <= cand + CNT_W'(1);
    if (cmd.d_init) dcnt <= D_W'(2);
    else if (cmd.d_inc) dcnt <= dcnt + D_W'(1);
    if (cmd.set_new_slots) begin
      new_slots <= cand;
      scr_cnt   <= '0;
    end else if (cmd.scr_push) begin
      scr_cnt <= scr_cnt + (SCR_W+1)'(1);
    end
    if (cmd.apply_new_slots) scr_rd <= '0;
    else if (cmd.reh_load) scr_rd <= scr_rd + (SCR_W+1)'(1);
    if (cmd.reh_load) place_key <= scr_q;
    else if (cmd.new_load) place_key <= item.key;
    if (cmd.div_start_prime || cmd.div_start_key) begin
      div_a   <= cmd.div_start_key ? place_key : KEY_W'(cand);
      div_d   <= cmd.div_start_key ? table_slots : CNT_W'(dcnt);
      div_r   <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_a   <= {div_a[KEY_W-2:0], 1'b0};
      div_r   <= (rs >= {1'b0, div_d}) ? CNT_W'(rs - {1'b0, div_d}) : rs[CNT_W-1:0];
      div_cnt <= div_cnt + DIVC_W'(1);
    end
    if (cmd.pos_load) begin
      pos       <= div_r[SLOT_W-1:0];
      probe_cnt <= '0;
    end else if (cmd.pos_inc) begin
      pos       <= ({1'b0, pos} == table_slots - CNT_W'(1)) ? '0 : pos + SLOT_W'(1);
      probe_cnt <= probe_cnt + CNT_W'(1);
    end
    if (cmd.resp_load) begin
      out_data.found         <= found_r;
      out_data.slot_key      <= skey_r;
      out_data.slot_state    <= sst_r;
      out_data.current_slots <= table_slots;
      out_data.error         <= err_r;
    end
  end

endmodule
`default_nettype wire

### design/lph_checker.sv
// Port-level checks of the hash table and the bind that attaches them.
`default_nettype none
module lph_checker (
  input wire                      clk,
  input wire                      rst,
  input wire                      in_valid,
  input wire                      in_stall,
  input lph_pkg::in_pkt_t         in_data,
  input wire                      out_valid,
  input wire                      out_stall,
  input lph_pkg::out_pkt_t        out_data
);
  import lph_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input transaction changed or dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_range_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error == ERR_RANGE |->
      out_data.slot_key == '0 && out_data.slot_state == ST_EMPTY)
    else $error("out-of-range status query returned slot contents");

  a_size_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.current_slots != '0 &&
      out_data.current_slots <= CNT_W'(MAX_SLOTS))
    else $error("table size out of range");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> out_data.error == ERR_OK)
    else $error("search hit reported with an error");

endmodule

bind linear_probing_hash_table lph_checker u_lph_checker (.*);
`default_nettype wire
